### hw/rtl/lpps_pkg.sv
// ----------------------------------------------------------------------------
// lpps_pkg
// Shared types, widths and constants for the line position PID steering core.
// ----------------------------------------------------------------------------
package lpps_pkg;

  // frame shape
  localparam int SENSOR_COUNT = 8;
  localparam int READING_BITS = 12;

  // derived datapath widths
  localparam int IDX_W      = $clog2(SENSOR_COUNT);
  localparam int WEIGHT_SUM = SENSOR_COUNT * (SENSOR_COUNT + 1) / 2;
  localparam int TOTAL_W    = READING_BITS + IDX_W;
  localparam int WSUM_W     = READING_BITS + $clog2(WEIGHT_SUM);
  localparam int POS_W      = $clog2(SENSOR_COUNT + 1);
  localparam int DSR_W      = TOTAL_W + POS_W - 1;
  localparam int CMP_W      = (WSUM_W > DSR_W) ? WSUM_W : DSR_W;

  localparam int GAIN_W    = 24;
  localparam int SP_W      = 5;
  localparam int POS_OUT_W = 8;
  localparam int ERR_W     = 11;
  localparam int D_W       = ERR_W + 1;
  localparam int INT_W     = 32;
  localparam int PREV_W    = 10;
  localparam int MB_W      = INT_W;
  localparam int PROD_W    = GAIN_W + 1 + MB_W;
  localparam int ACC_W     = PROD_W + 3;
  localparam int OUT_W     = 48;

  localparam int MUL_TERMS = 3;
  localparam int CNT_MAX_A = (SENSOR_COUNT - 1 > POS_W) ? SENSOR_COUNT - 1 : POS_W;
  localparam int CNT_MAX   = (CNT_MAX_A > MUL_TERMS - 1) ? CNT_MAX_A : MUL_TERMS - 1;
  localparam int CNT_W     = $clog2(CNT_MAX + 1);

  localparam logic [POS_OUT_W-1:0] LOST_POSITION = 8'hFF;

  // configuration register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SP = 3'd3;

  localparam logic [GAIN_W-1:0] KP_RESET = 24'd51200;
  localparam logic [GAIN_W-1:0] KI_RESET = 24'd51;
  localparam logic [GAIN_W-1:0] KD_RESET = 24'd30720;
  localparam logic [SP_W-1:0]   SP_RESET = 5'd9;

  typedef logic [READING_BITS-1:0] reading_t;

  typedef enum logic [1:0] {
    MUL_KP = 2'd0,
    MUL_KI = 2'd1,
    MUL_KD = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [SP_W-1:0]   sp;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     acc_step;
    logic     div_start;
    logic     div_step;
    logic     err_load;
    logic     mul_issue;
    mul_sel_t mul_sel;
    logic     fin;
    logic     out_load;
  } dp_cmd_t;

endpackage

### hw/rtl/lpps_ctrl.sv
// ----------------------------------------------------------------------------
// lpps_ctrl
// Sequencer: walks one frame through summing, division, the PID multiplies
// and the output register, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module lpps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output lpps_pkg::dp_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ACC  = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_ERR  = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_MACC = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t                       state, state_next;
  logic [lpps_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic                         out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ACC;
          cnt_next   = '0;
        end
      end
      S_ACC: begin
        cmd.acc_step = 1'b1;
        if (cnt == lpps_pkg::CNT_W'(lpps_pkg::SENSOR_COUNT - 1)) begin
          state_next = S_DIV;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIV: begin
        // first cycle loads the divider, then one quotient bit per cycle
        if (cnt == '0) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
        if (cnt == lpps_pkg::CNT_W'(lpps_pkg::POS_W)) begin
          state_next = S_ERR;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ERR: begin
        cmd.err_load = 1'b1;
        state_next   = S_MUL;
        cnt_next     = '0;
      end
      S_MUL: begin
        cmd.mul_issue = 1'b1;
        if (cnt == '0) begin
          cmd.mul_sel = lpps_pkg::MUL_KP;
        end else if (cnt == lpps_pkg::CNT_W'(1)) begin
          cmd.mul_sel = lpps_pkg::MUL_KI;
        end else begin
          cmd.mul_sel = lpps_pkg::MUL_KD;
        end
        if (cnt == lpps_pkg::CNT_W'(lpps_pkg::MUL_TERMS - 1)) begin
          state_next = S_MACC;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_MACC: begin
        // last product lands in the accumulator
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hw/rtl/lpps_dp.sv
// ----------------------------------------------------------------------------
// lpps_dp
// Datapath: reading shift line with running sums, restoring divider, shared
// gain multiplier with accumulator, PID state and the output register.
// ----------------------------------------------------------------------------
module lpps_dp (
  input  logic                                          clk,
  input  logic                                          rst,
  input  lpps_pkg::dp_cmd_t                             cmd,
  input  lpps_pkg::cfg_t                                cfg,
  input  lpps_pkg::reading_t [lpps_pkg::SENSOR_COUNT-1:0] sensors,
  output logic [lpps_pkg::POS_OUT_W-1:0]                line_position,
  output logic                                          line_lost,
  output logic signed [lpps_pkg::OUT_W-1:0]             pid_value,
  output logic signed [lpps_pkg::OUT_W-1:0]             left_change,
  output logic signed [lpps_pkg::OUT_W-1:0]             right_change
);

  localparam int N = lpps_pkg::SENSOR_COUNT;

  // frame sums
  lpps_pkg::reading_t [N-1:0]         rd;
  logic [lpps_pkg::TOTAL_W-1:0]       total;
  logic [lpps_pkg::TOTAL_W-1:0]       total_next;
  logic [lpps_pkg::WSUM_W-1:0]        wsum;

  // divider
  logic [lpps_pkg::WSUM_W-1:0]        rem;
  logic [lpps_pkg::DSR_W-1:0]         dsr;
  logic [lpps_pkg::POS_W-1:0]         quo;
  logic [lpps_pkg::CMP_W-1:0]         rem_x, dsr_x, diff_x;
  logic                               ge;

  // error and pid
  logic                               lost_c;
  logic [lpps_pkg::POS_OUT_W-1:0]     pos_c;
  logic signed [lpps_pkg::ERR_W-1:0]  err_c;
  logic signed [lpps_pkg::ERR_W-1:0]  err;
  logic                               lost;
  logic [lpps_pkg::POS_OUT_W-1:0]     pos;
  logic signed [lpps_pkg::D_W-1:0]    dterm;
  logic signed [lpps_pkg::GAIN_W:0]   mul_a;
  logic signed [lpps_pkg::MB_W-1:0]   mul_b;
  logic signed [lpps_pkg::PROD_W-1:0] prod;
  logic                               prod_vld;
  logic                               prod_dbl;
  logic signed [lpps_pkg::ACC_W-1:0]  addend;
  logic signed [lpps_pkg::ACC_W-1:0]  acc;
  logic                               acc_ovf;
  logic signed [lpps_pkg::OUT_W-1:0]  pid_sat;
  logic signed [lpps_pkg::OUT_W-1:0]  pid;

  // state
  logic signed [lpps_pkg::INT_W-1:0]  integral;
  logic signed [lpps_pkg::PREV_W-1:0] prev_err;
  logic signed [lpps_pkg::INT_W+1:0]  isum, isum_adj, ihalf;
  logic                               int_ovf;
  logic signed [lpps_pkg::INT_W-1:0]  int_sat;
  logic signed [lpps_pkg::ERR_W-1:0]  err_adj, err_half;
  logic signed [lpps_pkg::OUT_W-1:0]  pid_adj, pid_half;

  // highest-index reading is taken first so wsum picks up each weight by repetition
  assign total_next = total + lpps_pkg::TOTAL_W'(rd[N-1]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd    <= sensors;
      total <= '0;
      wsum  <= '0;
    end else if (cmd.acc_step) begin
      rd    <= {rd[N-2:0], lpps_pkg::reading_t'(0)};
      total <= total_next;
      wsum  <= wsum + lpps_pkg::WSUM_W'(total_next);
    end
  end

  assign rem_x  = lpps_pkg::CMP_W'(rem);
  assign dsr_x  = lpps_pkg::CMP_W'(dsr);
  assign ge     = (rem_x >= dsr_x);
  assign diff_x = rem_x - dsr_x;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= wsum;
      dsr <= lpps_pkg::DSR_W'(total) << (lpps_pkg::POS_W - 1);
      quo <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem <= diff_x[lpps_pkg::WSUM_W-1:0];
      end
      dsr <= dsr >> 1;
      quo <= {quo[lpps_pkg::POS_W-2:0], ge};
    end
  end

  assign lost_c = (total == '0);
  assign pos_c  = lost_c ? lpps_pkg::LOST_POSITION
                         : {{(lpps_pkg::POS_OUT_W-lpps_pkg::POS_W){1'b0}}, quo};
  assign err_c  = $signed({{(lpps_pkg::ERR_W-lpps_pkg::SP_W){1'b0}}, cfg.sp})
                - $signed({{(lpps_pkg::ERR_W-lpps_pkg::POS_OUT_W-1){1'b0}}, pos_c, 1'b0});

  assign dterm = $signed({err[lpps_pkg::ERR_W-1], err})
               - $signed({prev_err[lpps_pkg::PREV_W-1], prev_err, 1'b0});

  always_comb begin
    case (cmd.mul_sel)
      lpps_pkg::MUL_KP: begin
        mul_a = $signed({1'b0, cfg.kp});
        mul_b = {{(lpps_pkg::MB_W-lpps_pkg::ERR_W){err[lpps_pkg::ERR_W-1]}}, err};
      end
      lpps_pkg::MUL_KI: begin
        mul_a = $signed({1'b0, cfg.ki});
        mul_b = integral;
      end
      lpps_pkg::MUL_KD: begin
        mul_a = $signed({1'b0, cfg.kd});
        mul_b = {{(lpps_pkg::MB_W-lpps_pkg::D_W){dterm[lpps_pkg::D_W-1]}}, dterm};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // integral term carries an extra factor of two
  assign addend = prod_dbl
    ? {{(lpps_pkg::ACC_W-lpps_pkg::PROD_W-1){prod[lpps_pkg::PROD_W-1]}}, prod, 1'b0}
    : {{(lpps_pkg::ACC_W-lpps_pkg::PROD_W){prod[lpps_pkg::PROD_W-1]}}, prod};

  assign acc_ovf = !((&acc[lpps_pkg::ACC_W-1:lpps_pkg::OUT_W-1]) ||
                     (~|acc[lpps_pkg::ACC_W-1:lpps_pkg::OUT_W-1]));
  assign pid_sat = acc_ovf
    ? (acc[lpps_pkg::ACC_W-1] ? {1'b1, {(lpps_pkg::OUT_W-1){1'b0}}}
                              : {1'b0, {(lpps_pkg::OUT_W-1){1'b1}}})
    : acc[lpps_pkg::OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      err  <= err_c;
      lost <= lost_c;
      pos  <= pos_c;
    end
    if (cmd.mul_issue) begin
      prod <= mul_a * mul_b;
    end
    prod_dbl <= (cmd.mul_sel == lpps_pkg::MUL_KI);
    if (cmd.err_load) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + addend;
    end
    if (cmd.fin) begin
      pid <= pid_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_issue;
    end
  end

  // halving rounds toward zero: add the sign bit before the arithmetic shift
  assign isum     = $signed({integral[lpps_pkg::INT_W-1], integral, 1'b0})
                  + $signed({{(lpps_pkg::INT_W+2-lpps_pkg::ERR_W){err[lpps_pkg::ERR_W-1]}},
                             err});
  assign isum_adj = isum + $signed({{(lpps_pkg::INT_W+1){1'b0}}, isum[lpps_pkg::INT_W+1]});
  assign ihalf    = isum_adj >>> 1;
  assign int_ovf  = !((&ihalf[lpps_pkg::INT_W+1:lpps_pkg::INT_W-1]) ||
                      (~|ihalf[lpps_pkg::INT_W+1:lpps_pkg::INT_W-1]));
  assign int_sat  = int_ovf
    ? (ihalf[lpps_pkg::INT_W+1] ? {1'b1, {(lpps_pkg::INT_W-1){1'b0}}}
                                : {1'b0, {(lpps_pkg::INT_W-1){1'b1}}})
    : ihalf[lpps_pkg::INT_W-1:0];

  assign err_adj  = err + $signed({{(lpps_pkg::ERR_W-1){1'b0}}, err[lpps_pkg::ERR_W-1]});
  assign err_half = err_adj >>> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      prev_err <= '0;
    end else if (cmd.fin) begin
      integral <= int_sat;
      prev_err <= err_half[lpps_pkg::PREV_W-1:0];
    end
  end

  assign pid_adj  = pid + $signed({{(lpps_pkg::OUT_W-1){1'b0}}, pid[lpps_pkg::OUT_W-1]});
  assign pid_half = pid_adj >>> 1;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      line_position <= pos;
      line_lost     <= lost;
      pid_value     <= pid;
      left_change   <= pid_half;
      right_change  <= -pid_half;
    end
  end

endmodule

### hw/rtl/line_position_pid_steering_core.sv
// ----------------------------------------------------------------------------
// line_position_pid_steering_core
// Weighted line position from eight reflectance readings, PID on the
// position error and the resulting left and right wheel changes.
// ----------------------------------------------------------------------------
// One input beat carries a frame of eight sensor readings; one output beat
// carries the position, the lost flag, the saturated PID value and the two
// wheel changes. Both channels use valid/stall; the configuration channel
// (valid/ready, always ready) writes kp, ki, kd and the setpoint by index,
// and writes to unused indexes are dropped.
// From acceptance to output valid a frame passes through the running sums
// (one reading per cycle), the restoring divider, the error register,
// 3 multiplies through the single gain multiplier plus an accumulate step,
// a step to saturate and update the PID state, and the load of the
// output register. The next frame is taken in the cycle after the
// output register is loaded, so a frame is never taken while one is in work.
// A stalled output holds its beat; the finished frame then waits in the
// datapath until the output register frees and no new frame is taken.
// Reset returns the gains and setpoint to their defaults, clears the
// integrator and previous error and clears the output valid flag.
// ----------------------------------------------------------------------------
module line_position_pid_steering_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [lpps_pkg::READING_BITS-1:0]    sensor_0,
  input  logic [lpps_pkg::READING_BITS-1:0]    sensor_1,
  input  logic [lpps_pkg::READING_BITS-1:0]    sensor_2,
  input  logic [lpps_pkg::READING_BITS-1:0]    sensor_3,
  input  logic [lpps_pkg::READING_BITS-1:0]    sensor_4,
  input  logic [lpps_pkg::READING_BITS-1:0]    sensor_5,
  input  logic [lpps_pkg::READING_BITS-1:0]    sensor_6,
  input  logic [lpps_pkg::READING_BITS-1:0]    sensor_7,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lpps_pkg::POS_OUT_W-1:0]       line_position,
  output logic                                 line_lost,
  output logic signed [lpps_pkg::OUT_W-1:0]    pid_value,
  output logic signed [lpps_pkg::OUT_W-1:0]    left_change,
  output logic signed [lpps_pkg::OUT_W-1:0]    right_change,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lpps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lpps_pkg::CFG_DATA_W-1:0]      cfg_data
);

  lpps_pkg::cfg_t                                   cfg;
  lpps_pkg::dp_cmd_t                                cmd;
  lpps_pkg::reading_t [lpps_pkg::SENSOR_COUNT-1:0]  sensors;

  assign sensors = {sensor_7, sensor_6, sensor_5, sensor_4,
                    sensor_3, sensor_2, sensor_1, sensor_0};

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp <= lpps_pkg::KP_RESET;
      cfg.ki <= lpps_pkg::KI_RESET;
      cfg.kd <= lpps_pkg::KD_RESET;
      cfg.sp <= lpps_pkg::SP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpps_pkg::CFG_KP: cfg.kp <= cfg_data;
        lpps_pkg::CFG_KI: cfg.ki <= cfg_data;
        lpps_pkg::CFG_KD: cfg.kd <= cfg_data;
        lpps_pkg::CFG_SP: cfg.sp <= cfg_data[lpps_pkg::SP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lpps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lpps_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .sensors       (sensors),
    .line_position (line_position),
    .line_lost     (line_lost),
    .pid_value     (pid_value),
    .left_change   (left_change),
    .right_change  (right_change)
  );

`ifndef SYNTHESIS
  // a frame once taken keeps the input side closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a frame is in progress");

  a_lost_position: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_lost == (line_position == lpps_pkg::LOST_POSITION)))
    else $error("lost flag and position disagree");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !line_lost) |->
      (line_position != '0) &&
      (line_position <= lpps_pkg::POS_OUT_W'(lpps_pkg::SENSOR_COUNT)))
    else $error("line position outside sensor range");

  a_wheel_mirror: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (right_change == -left_change))
    else $error("wheel changes are not mirrored");
`endif

endmodule
